### design/trt_pkg.sv
// ---------------------------------------------------------------------------
// trt_pkg
// Shared types and codes for the timeline retire table.
// ---------------------------------------------------------------------------
`default_nettype none
package trt_pkg;
  localparam int DEPTH_DEFAULT = 32;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_COLLECT = 2'd1;
  localparam logic [1:0] ACT_KIND    = 2'd2;
  localparam logic [1:0] ACT_FINISH  = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RETIRED  = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] fence_value;
    logic [47:0] handle;
    logic [7:0]  kind;
    logic [63:0] reached;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] out_handle;
    logic [7:0]  out_kind;
    logic [5:0]  retired_count;
    logic [5:0]  fill_level;
    logic [5:0]  high_water;
    logic [31:0] duplicate_total;
    logic [31:0] violation_total;
    logic        last;
  } result_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic emit_phase;
    logic update;
    logic done;
  } cmd_t;
endpackage
`default_nettype wire

### design/trt_datapath.sv
// ---------------------------------------------------------------------------
// trt_datapath
// Entry memory, scan accumulators, statistics and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module trt_datapath #(
  parameter int DEPTH = trt_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire trt_pkg::item_t  in_item,
  input  wire trt_pkg::cmd_t   cmd,
  input  wire logic [AW-1:0]   rd_addr,
  output logic [CW-1:0]        occ,
  output logic                 strobe,
  output trt_pkg::result_t     result
);
  import trt_pkg::*;

  logic [63:0] mem_tl [DEPTH];
  logic [47:0] mem_h  [DEPTH];
  logic [7:0]  mem_k  [DEPTH];

  item_t       item_q;
  logic [63:0] rd_tl;
  logic [47:0] rd_h;
  logic [7:0]  rd_k;
  logic        vld_q, emit_q;
  logic        dup_f, ahead_f;
  logic [CW-1:0] go_cnt, kept;
  logic [CW-1:0] peak;
  logic [31:0] dupc, viol;

  logic [CW-1:0] occ_next, peak_next, kept_next;
  logic [31:0]   dupc_next, viol_next;
  logic          wr_en, str_next, go;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_tl;
  logic [47:0]   wr_h;
  logic [7:0]    wr_k;
  result_t       res_next;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  assign go = (item_q.action == ACT_FINISH) ||
              ((rd_tl <= item_q.reached) &&
               ((item_q.action != ACT_KIND) || (rd_k == item_q.kind)));

  always_comb begin
    occ_next  = occ;
    peak_next = peak;
    dupc_next = dupc;
    viol_next = viol;
    kept_next = kept;
    wr_en     = 1'b0;
    wr_addr   = kept[AW-1:0];
    wr_tl     = rd_tl;
    wr_h      = rd_h;
    wr_k      = rd_k;
    str_next  = 1'b0;
    res_next  = '0;
    if (cmd.update) begin
      if (item_q.action == ACT_PUSH) begin
        str_next      = 1'b1;
        res_next.last = 1'b1;
        priority if (dup_f) begin
          dupc_next       = sat_inc(dupc);
          viol_next       = sat_inc(viol);
          res_next.status = ST_DUP;
        end else if (occ == CW'(DEPTH)) begin
          res_next.status     = ST_FULL;
          res_next.out_handle = item_q.handle;
          res_next.out_kind   = item_q.kind;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = occ[AW-1:0];
          wr_tl     = item_q.fence_value;
          wr_h      = item_q.handle;
          wr_k      = item_q.kind;
          occ_next  = occ + 1'b1;
          if (occ_next > peak) peak_next = occ_next;
          res_next.status = ST_ACCEPTED;
        end
      end else if (item_q.action == ACT_FINISH) begin
        occ_next  = '0;
        peak_next = '0;
        dupc_next = '0;
        if (ahead_f) viol_next = sat_inc(viol);
      end else begin
        occ_next = occ - go_cnt;
      end
    end else if (vld_q && emit_q) begin
      if (go) begin
        str_next            = 1'b1;
        res_next.status     = ST_RETIRED;
        res_next.out_handle = rd_h;
        res_next.out_kind   = rd_k;
      end else if (item_q.action != ACT_FINISH) begin
        wr_en     = 1'b1;
        kept_next = kept + 1'b1;
      end
    end else if (cmd.done) begin
      str_next               = 1'b1;
      res_next.status        = ST_DONE;
      res_next.retired_count = 6'(go_cnt);
      res_next.last          = 1'b1;
    end
    res_next.fill_level      = 6'(occ_next);
    res_next.high_water      = 6'(peak_next);
    res_next.duplicate_total = dupc_next;
    res_next.violation_total = viol_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_tl[wr_addr] <= wr_tl;
      mem_h[wr_addr]  <= wr_h;
      mem_k[wr_addr]  <= wr_k;
    end
    rd_tl  <= mem_tl[rd_addr];
    rd_h   <= mem_h[rd_addr];
    rd_k   <= mem_k[rd_addr];
    result <= res_next;
    if (cmd.load) item_q <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= '0;
      peak    <= '0;
      dupc    <= '0;
      viol    <= '0;
      strobe  <= 1'b0;
      vld_q   <= 1'b0;
      emit_q  <= 1'b0;
      dup_f   <= 1'b0;
      ahead_f <= 1'b0;
      go_cnt  <= '0;
      kept    <= '0;
    end else begin
      occ    <= occ_next;
      peak   <= peak_next;
      dupc   <= dupc_next;
      viol   <= viol_next;
      strobe <= str_next;
      vld_q  <= cmd.rd_en;
      emit_q <= cmd.emit_phase;
      if (cmd.load) begin
        dup_f   <= 1'b0;
        ahead_f <= 1'b0;
        go_cnt  <= '0;
        kept    <= '0;
      end else begin
        kept <= kept_next;
        if (vld_q && !emit_q) begin
          if (rd_h == item_q.handle && rd_k == item_q.kind) dup_f <= 1'b1;
          if (rd_tl > item_q.reached) ahead_f <= 1'b1;
          if (go) go_cnt <= go_cnt + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/trt_ctrl.sv
// ---------------------------------------------------------------------------
// trt_ctrl
// Sequencer: scan pass and update; then, for all but a push, emit pass and done result.
// ---------------------------------------------------------------------------
`default_nettype none
module trt_ctrl #(
  parameter int DEPTH = trt_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    action,
  input  wire logic [CW-1:0] occ,
  output logic               busy,
  output trt_pkg::cmd_t      cmd,
  output logic [AW-1:0]      rd_addr
);
  import trt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_EMIT, S_DONE} state_t;

  state_t        state;
  logic [CW-1:0] idx, n;
  logic          push_q;

  assign busy           = (state != S_IDLE);
  assign rd_addr        = idx[AW-1:0];
  assign cmd.load       = (state == S_IDLE) && start;
  assign cmd.rd_en      = ((state == S_SCAN) || (state == S_EMIT)) && (idx != n);
  assign cmd.emit_phase = (state == S_EMIT);
  assign cmd.update     = (state == S_UPD);
  assign cmd.done       = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      n      <= '0;
      push_q <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state  <= S_SCAN;
            idx    <= '0;
            n      <= occ;
            push_q <= (action == ACT_PUSH);
          end
        end
        S_SCAN: begin
          if (idx == n) state <= S_UPD;
          else idx <= idx + 1'b1;
        end
        S_UPD: begin
          idx   <= '0;
          state <= push_q ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (idx == n) state <= S_DONE;
          else idx <= idx + 1'b1;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/timeline_retire_table.sv
// ---------------------------------------------------------------------------
// timeline_retire_table
// Table of pending retirements released by a reached timeline value.
// ---------------------------------------------------------------------------
// items are taken one at a time; a push makes one pass over the entry memory, the others two
// a collect or finish reports each retired entry during its second pass; strobe marks each result for one cycle
// synchronous reset empties the table and clears all counters
`default_nettype none
module timeline_retire_table #(
  parameter int DEPTH = trt_pkg::DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire trt_pkg::item_t   cmd,
  output logic                  busy,
  output logic                  strobe,
  output trt_pkg::result_t      result
);
  import trt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          ctl;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] occ;

  trt_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(cmd.action), .occ(occ),
    .busy(busy), .cmd(ctl), .rd_addr(rd_addr)
  );

  trt_datapath #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_dp (
    .clk(clk), .rst(rst), .in_item(cmd), .cmd(ctl), .rd_addr(rd_addr),
    .occ(occ), .strobe(strobe), .result(result)
  );

  a_mid_retired: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> result.status == ST_RETIRED)
    else $error("non-final result is not a retired entry");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && result.last)
    else $error("item ended without final result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> result.fill_level <= 6'(DEPTH) && result.high_water <= 6'(DEPTH))
    else $error("fill level beyond depth");
endmodule
`default_nettype wire
